// ===== design/sorted_priority_queue_unit_assert.svh =====
// Assertion macros for the sorted priority queue unit
`ifndef SORTED_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define SPQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted priority queue check failed");

`define SPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted priority queue check failed");

`else

`define SPQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)

`define SPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== design/spq_pkg.sv =====
// Types, constants and codes shared by the sorted priority queue files
`timescale 1ns / 1ps

package spq_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        CMD_INSERT   = 3'd0,
        CMD_POP_HEAD = 3'd1,
        CMD_POP_TAIL = 3'd2,
        CMD_REMOVE   = 3'd3,
        CMD_FIND     = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_FULL     = 2'd1,
        STATUS_EMPTY    = 2'd2,
        STATUS_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic {
        FSM_IDLE = 1'b0,
        FSM_EXEC = 1'b1
    } fsm_t;

    typedef struct packed {
        logic [2:0]         cmd;
        logic [7:0]         id;
        logic signed [31:0] key;
    } in_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [7:0]         out_id;
        logic signed [31:0] out_key;
        logic [6:0]         count;
        logic               is_empty;
        logic               is_full;
    } out_t;

    typedef struct packed {
        logic [7:0]         id;
        logic signed [31:0] key;
    } entry_t;

    typedef struct packed {
        logic [2:0]         cmd;
        logic               en;
        logic [7:0]         id;
        logic signed [31:0] key;
        logic [CNT_W-1:0]   count;
    } ctrl_t;

    typedef struct packed {
        logic ge;
        logic seen;
    } link_t;

endpackage

// ===== design/spq_cell.sv =====
// One storage cell of the sorted entry chain
`timescale 1ns / 1ps

module spq_cell (
    input  logic                       aclk,
    input  spq_pkg::ctrl_t             ctrl,
    input  logic [spq_pkg::IDX_W-1:0]  idx,
    input  spq_pkg::entry_t            left_entry,
    input  spq_pkg::entry_t            right_entry,
    input  spq_pkg::link_t             link_in,
    output spq_pkg::link_t             link_out,
    output spq_pkg::entry_t            entry_out,
    output spq_pkg::entry_t            hit_entry
);
    import spq_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;
    logic   occ;
    logic   ge;
    logic   match;
    logic   hit;

    assign occ   = CNT_W'(idx) < ctrl.count;
    assign ge    = occ && (entry_reg.key >= ctrl.key);
    assign match = occ && (entry_reg.id == ctrl.id);

    assign link_out.ge   = ge;
    assign link_out.seen = link_in.seen | match;
    assign entry_out     = entry_reg;
    assign hit_entry     = hit ? entry_reg : '0;

    always_comb begin
        hit        = 1'b0;
        entry_next = entry_reg;
        unique case (ctrl.cmd)
            CMD_INSERT: begin
                if (!ge) begin
                    entry_next = link_in.ge ? entry_t'{id: ctrl.id, key: ctrl.key} : left_entry;
                end
            end
            CMD_POP_HEAD: begin
                hit        = occ && (idx == '0);
                entry_next = right_entry;
            end
            CMD_POP_TAIL: begin
                hit = (CNT_W'(idx) + CNT_W'(1)) == ctrl.count;
            end
            CMD_REMOVE: begin
                hit = match && !link_in.seen;
                if (link_in.seen || match) begin
                    entry_next = right_entry;
                end
            end
            CMD_FIND: begin
                hit = match && !link_in.seen;
            end
            default: begin
                hit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ctrl.en) begin
            entry_reg <= entry_next;
        end
    end

endmodule

// ===== design/sorted_priority_queue_unit.sv =====
// Top level of the sorted priority queue: command control and the cell chain
`timescale 1ns / 1ps

// Keeps up to CAPACITY (id, key) entries in a chain of cells, head first, sorted by
// descending signed key with equal keys in arrival order. Every command is one transfer
// in and one result transfer out. A command has an accept cycle and an execute cycle, in
// which every cell compares against the command in parallel and shifts its entry to or
// from its neighbour where the command needs it, so the time does not depend on the fill level.
// The next command is taken in the cycle after the execute cycle; the execute cycle waits
// only while an earlier result has not yet been taken. No clearing pass is needed after reset.
module sorted_priority_queue_unit (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  spq_pkg::in_t  s_payload,
    output logic          m_valid,
    input  logic          m_ready,
    output spq_pkg::out_t m_payload
);
    import spq_pkg::*;

    fsm_t             state_reg, state_next;
    logic             s_ready_reg;
    logic             m_valid_reg, m_valid_next;
    out_t             out_reg, out_next;
    in_t              cmd_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             fire;
    logic             upd_en;
    ctrl_t            ctrl;
    link_t            link_w  [CAPACITY:0];
    entry_t           ent_w   [CAPACITY-1:0];
    entry_t           hit_w   [CAPACITY-1:0];
    entry_t           sel;
    logic             is_full_now;
    logic             is_empty_now;
    logic             found;

    assign s_ready = s_ready_reg;
    assign m_valid = m_valid_reg;
    assign m_payload = out_reg;

    assign is_full_now  = cnt_reg == CNT_W'(CAPACITY);
    assign is_empty_now = cnt_reg == '0;
    assign found        = link_w[CAPACITY].seen;

    assign ctrl.cmd   = cmd_reg.cmd;
    assign ctrl.en    = upd_en;
    assign ctrl.id    = cmd_reg.id;
    assign ctrl.key   = cmd_reg.key;
    assign ctrl.count = cnt_reg;

    assign link_w[0].ge   = 1'b1;
    assign link_w[0].seen = 1'b0;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        entry_t left_e;
        entry_t right_e;
        if (i == 0) begin : g_first
            assign left_e = '0;
        end else begin : g_mid
            assign left_e = ent_w[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign right_e = '0;
        end else begin : g_inner
            assign right_e = ent_w[i+1];
        end
        spq_cell u_cell (
            .aclk        (aclk),
            .ctrl        (ctrl),
            .idx         (IDX_W'(i)),
            .left_entry  (left_e),
            .right_entry (right_e),
            .link_in     (link_w[i]),
            .link_out    (link_w[i+1]),
            .entry_out   (ent_w[i]),
            .hit_entry   (hit_w[i])
        );
    end

    always_comb begin
        sel = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            sel = sel | hit_w[i];
        end
    end

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        fire         = 1'b0;
        unique case (state_reg)
            FSM_IDLE: begin
                if (s_valid && s_ready_reg) begin
                    state_next = FSM_EXEC;
                end
            end
            FSM_EXEC: begin
                if (!m_valid_reg || m_ready) begin
                    fire         = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = FSM_IDLE;
                end
            end
            default: begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    always_comb begin
        logic [1:0] st;
        st                = STATUS_OK;
        cnt_next          = cnt_reg;
        upd_en            = 1'b0;
        out_next.out_id   = '0;
        out_next.out_key  = '0;
        unique case (cmd_reg.cmd)
            CMD_INSERT: begin
                if (is_full_now) begin
                    st = STATUS_FULL;
                end else begin
                    upd_en           = fire;
                    cnt_next         = cnt_reg + CNT_W'(1);
                    out_next.out_id  = cmd_reg.id;
                    out_next.out_key = cmd_reg.key;
                end
            end
            CMD_POP_HEAD, CMD_POP_TAIL: begin
                if (is_empty_now) begin
                    st = STATUS_EMPTY;
                end else begin
                    upd_en           = fire;
                    cnt_next         = cnt_reg - CNT_W'(1);
                    out_next.out_id  = sel.id;
                    out_next.out_key = sel.key;
                end
            end
            CMD_REMOVE, CMD_FIND: begin
                if (is_empty_now) begin
                    st = STATUS_EMPTY;
                end else if (!found) begin
                    st = STATUS_NOTFOUND;
                end else begin
                    out_next.out_id  = sel.id;
                    out_next.out_key = sel.key;
                    if (cmd_reg.cmd == CMD_REMOVE) begin
                        upd_en   = fire;
                        cnt_next = cnt_reg - CNT_W'(1);
                    end
                end
            end
            default: begin
                st = STATUS_OK;
            end
        endcase
        out_next.status   = st;
        out_next.count    = 7'(cnt_next);
        out_next.is_empty = cnt_next == '0;
        out_next.is_full  = cnt_next == CNT_W'(CAPACITY);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= FSM_IDLE;
            s_ready_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            cnt_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            s_ready_reg <= state_next == FSM_IDLE;
            m_valid_reg <= m_valid_next;
            if (fire) begin
                cnt_reg <= cnt_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready_reg) begin
            cmd_reg <= s_payload;
        end
        if (fire) begin
            out_reg <= out_next;
        end
    end

`include "sorted_priority_queue_unit_assert.svh"

    `SPQ_ASSERT_IMPL(a_ready_only_idle, aclk, aresetn, s_ready_reg, state_reg == FSM_IDLE)
    `SPQ_ASSERT_IMPL(a_count_bound, aclk, aresetn, 1'b1, cnt_reg <= CNT_W'(CAPACITY))
    `SPQ_ASSERT_NEXT(a_count_held, aclk, aresetn, !fire, $stable(cnt_reg))
    `SPQ_ASSERT_IMPL(a_full_flag, aclk, aresetn, m_valid_reg && out_reg.status == STATUS_FULL, out_reg.is_full)

endmodule

// ===== verif/sorted_priority_queue_unit_tb.sv =====
// Self-checking testbench for the sorted priority queue unit: directed and random commands
`timescale 1ns / 1ps

module sorted_priority_queue_unit_tb;

    import spq_pkg::*;

    localparam int unsigned RANDOM_ITEMS = 1050;
    localparam int unsigned CALM_ITEMS   = 150;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned CYCLE_LIMIT  = 200_000;
    localparam int unsigned SETTLE       = 20;

    class spq_scoreboard;
        entry_t      held_entries[$];
        out_t        due_results[$];
        int unsigned mismatches;
        int unsigned checked;
        int unsigned commands;
        int unsigned peak_fill;
        int unsigned status_seen[4];

        function int unsigned pending();
            return due_results.size();
        endfunction

        function void note_command(in_t c);
            out_t   r;
            entry_t e;
            int     pos;
            r = '0;
            r.status = STATUS_OK;
            case (c.cmd)
                CMD_INSERT: begin
                    if (held_entries.size() >= CAPACITY) begin
                        r.status = STATUS_FULL;
                    end else begin
                        pos = 0;
                        while (pos < held_entries.size() &&
                               $signed(held_entries[pos].key) >= $signed(c.key))
                            pos++;
                        e.id = c.id;
                        e.key = c.key;
                        held_entries.insert(pos, e);
                        r.out_id = c.id;
                        r.out_key = c.key;
                    end
                end
                CMD_POP_HEAD, CMD_POP_TAIL, CMD_REMOVE, CMD_FIND: begin
                    if (held_entries.size() == 0) begin
                        r.status = STATUS_EMPTY;
                    end else begin
                        if (c.cmd == CMD_POP_HEAD) begin
                            pos = 0;
                        end else if (c.cmd == CMD_POP_TAIL) begin
                            pos = held_entries.size() - 1;
                        end else begin
                            pos = 0;
                            while (pos < held_entries.size() && held_entries[pos].id != c.id)
                                pos++;
                        end
                        if (pos >= held_entries.size()) begin
                            r.status = STATUS_NOTFOUND;
                        end else begin
                            r.out_id = held_entries[pos].id;
                            r.out_key = held_entries[pos].key;
                            if (c.cmd != CMD_FIND)
                                held_entries.delete(pos);
                        end
                    end
                end
                default: ;
            endcase
            r.count = 7'(held_entries.size());
            r.is_empty = (held_entries.size() == 0);
            r.is_full = (held_entries.size() == CAPACITY);
            if (held_entries.size() > peak_fill)
                peak_fill = held_entries.size();
            status_seen[r.status]++;
            commands++;
            due_results.push_back(r);
        endfunction

        task report_mismatch(string what);
            $display("ERROR @%0t: result %0d: %s", $realtime, checked, what);
            mismatches++;
        endtask

        task check_result(out_t got);
            out_t w;
            if (due_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result %p", got));
                return;
            end
            w = due_results.pop_front();
            if (got.status !== w.status)
                report_mismatch($sformatf("status %0d, want %0d", got.status, w.status));
            if (got.out_id !== w.out_id)
                report_mismatch($sformatf("out_id %0d, want %0d", got.out_id, w.out_id));
            if (got.out_key !== w.out_key)
                report_mismatch($sformatf("out_key %0d, want %0d", got.out_key, w.out_key));
            if (got.count !== w.count)
                report_mismatch($sformatf("count %0d, want %0d", got.count, w.count));
            if (got.is_empty !== w.is_empty)
                report_mismatch($sformatf("is_empty %b, want %b", got.is_empty, w.is_empty));
            if (got.is_full !== w.is_full)
                report_mismatch($sformatf("is_full %b, want %b", got.is_full, w.is_full));
            checked++;
        endtask
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_t         s_payload;
    logic        m_valid;
    logic        m_ready;
    out_t        m_payload;

    bit          calm;
    bit          hold_req;
    int unsigned cycles;

    spq_scoreboard sb = new();

    sorted_priority_queue_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                sb.check_result(m_payload);
            if (s_valid && s_ready)
                sb.note_command(s_payload);
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("ERROR: timeout after %0d cycles", cycles);
            $display("sorted_priority_queue_unit_tb failed");
            $finish;
        end
    end

    function automatic in_t make_command(logic [2:0] cmd, logic [7:0] id, logic [31:0] key);
        in_t c;
        c.cmd = cmd;
        c.id = id;
        c.key = key;
        return c;
    endfunction

    function automatic in_t rand_command(int unsigned insert_pct);
        in_t         c;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < insert_pct)
            c.cmd = CMD_INSERT;
        else if (pick >= 97)
            c.cmd = 3'($urandom_range(5, 7));
        else
            c.cmd = 3'($urandom_range(CMD_POP_HEAD, CMD_FIND));
        // keep ids in a narrow pool most of the time so removal and lookup hit
        c.id = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 11));
        case ($urandom_range(0, 3))
            0: c.key = $signed($urandom_range(0, 6)) - 3;
            1: c.key = $urandom;
            2: begin
                case ($urandom_range(0, 3))
                    0: c.key = 32'h7fff_ffff;
                    1: c.key = 32'h8000_0000;
                    2: c.key = '0;
                    default: c.key = '1;
                endcase
            end
            default: c.key = $signed($urandom_range(0, 2000)) - 1000;
        endcase
        return c;
    endfunction

    task automatic send_command(input in_t c);
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_payload <= c;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic run_receiver();
        int unsigned held_cycles;
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                for (held_cycles = 0; held_cycles < HOLD_CYCLES; held_cycles++)
                    @(posedge aclk);
                hold_req = 1'b0;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    endtask

    task automatic run_directed();
        send_command(make_command(CMD_POP_HEAD, 8'd1, 32'd0));
        send_command(make_command(CMD_POP_TAIL, 8'd2, 32'd0));
        send_command(make_command(CMD_REMOVE, 8'd3, 32'd0));
        send_command(make_command(CMD_FIND, 8'd4, 32'd0));
        send_command(make_command(3'd5, 8'd0, 32'd0));
        send_command(make_command(3'd6, 8'hff, 32'hffff_ffff));
        send_command(make_command(3'd7, 8'h5a, 32'h8000_0000));
        send_command(make_command(CMD_INSERT, 8'hff, 32'h7fff_ffff));
        send_command(make_command(CMD_INSERT, 8'h00, 32'h8000_0000));
        send_command(make_command(CMD_INSERT, 8'd5, 32'd0));
        send_command(make_command(CMD_INSERT, 8'd6, 32'd0));
        send_command(make_command(CMD_INSERT, 8'd5, 32'hffff_ffff));
        send_command(make_command(CMD_FIND, 8'd5, 32'd0));
        send_command(make_command(CMD_FIND, 8'd77, 32'd0));
        send_command(make_command(CMD_REMOVE, 8'd77, 32'd0));
        send_command(make_command(3'd7, 8'hff, 32'hffff_ffff));
        send_command(make_command(CMD_POP_TAIL, 8'd0, 32'd0));
        // duplicate id at the tail: pop tail takes the tail, not the earlier match
        send_command(make_command(CMD_INSERT, 8'd6, -32'sd100));
        send_command(make_command(CMD_POP_TAIL, 8'd6, 32'd0));
        send_command(make_command(CMD_REMOVE, 8'd5, 32'd0));
        send_command(make_command(CMD_POP_HEAD, 8'd0, 32'd0));
        send_command(make_command(CMD_POP_HEAD, 8'd0, 32'd0));
        send_command(make_command(CMD_POP_HEAD, 8'd0, 32'd0));
        send_command(make_command(CMD_POP_HEAD, 8'd0, 32'd0));
    endtask

    task automatic run_random();
        int unsigned issued;
        int unsigned seg_len;
        int unsigned insert_pct;
        int unsigned phase;
        issued = 0;
        phase = 0;
        while (issued < RANDOM_ITEMS) begin
            case (phase % 4)
                0: insert_pct = 88;
                2: insert_pct = 12;
                default: insert_pct = 50;
            endcase
            seg_len = (phase % 2 == 0) ? $urandom_range(90, 130) : $urandom_range(20, 60);
            for (int k = 0; k < seg_len && issued < RANDOM_ITEMS; k++) begin
                if (issued == 320)
                    hold_req = 1'b1;
                if (issued == RANDOM_ITEMS - CALM_ITEMS)
                    calm = 1'b1;
                send_command(rand_command(insert_pct));
                issued++;
            end
            phase++;
        end
    endtask

    initial begin
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_payload <= '0;
        m_ready <= 1'b0;
        calm = 1'b0;
        hold_req = 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        fork
            run_receiver();
        join_none
        run_directed();
        run_random();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        $display("Run: %0d commands, %0d results checked, peak fill %0d of %0d",
                 sb.commands, sb.checked, sb.peak_fill, CAPACITY);
        $display("Outcomes: %0d ok, %0d refused full, %0d on empty, %0d id absent; %0d mismatches",
                 sb.status_seen[STATUS_OK], sb.status_seen[STATUS_FULL],
                 sb.status_seen[STATUS_EMPTY], sb.status_seen[STATUS_NOTFOUND], sb.mismatches);
        if (sb.mismatches == 0)
            $display("sorted_priority_queue_unit_tb passed");
        else
            $display("sorted_priority_queue_unit_tb failed");
        $finish;
    end

endmodule
